// ===== design/qgrb_pkg.sv =====
// Package for the quorum-gated reorder buffer.
// Payload structs, controller/datapath command and status structs, codes.
// No dependencies.
package qgrb_pkg;

   localparam int SEQ_W    = 32;
   localparam int TAG_W    = 32;
   localparam int CMD_W    = 2;
   localparam int SID_W    = 3;
   localparam int STAT_W   = 3;
   localparam int QUORUM_W = 4;
   localparam int MASK_W   = 8;
   localparam int CSR_W    = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SKIP   = 2'd1;

   localparam logic [STAT_W-1:0] ST_COUNTED  = 3'd0;
   localparam logic [STAT_W-1:0] ST_APPLIED  = 3'd1;
   localparam logic [STAT_W-1:0] ST_INVALID  = 3'd2;
   localparam logic [STAT_W-1:0] ST_ALREADY  = 3'd3;
   localparam logic [STAT_W-1:0] ST_OUTSIDE  = 3'd4;

   localparam logic KIND_ENTRY = 1'b0;
   localparam logic KIND_ACK   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_QUORUM = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK   = 1'd1;

   localparam logic [QUORUM_W-1:0] QUORUM_RST = 4'd2;
   localparam logic [MASK_W-1:0]   MASK_RST   = 8'hFF;
   localparam logic [SEQ_W-1:0]    NEXT_RST   = 32'd1;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [SID_W-1:0] server_id;
      logic [SEQ_W-1:0] seq;
      logic [TAG_W-1:0] payload_tag;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [SEQ_W-1:0]  out_seq;
      logic [TAG_W-1:0]  out_tag;
      logic [STAT_W-1:0] status;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic check;
      logic lookup;
      logic vote;
      logic pop;
      logic out_ack;
   } qgrb_ctl_type;

   typedef struct packed {
      logic voting;
      logic apply;
      logic head_ready;
   } qgrb_sts_type;

endpackage

// ===== design/qgrb_ctrl.sv =====
// Controller FSM for the quorum-gated reorder buffer.
// Sequences check, lookup, vote, drain and ack; uses qgrb_pkg.
module qgrb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  qgrb_pkg::qgrb_sts_type  sts,
   output qgrb_pkg::qgrb_ctl_type  ctl
);
   import qgrb_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_LOOKUP = 3'd2;
   localparam logic [2:0] S_VOTE   = 3'd3;
   localparam logic [2:0] S_DRAIN  = 3'd4;
   localparam logic [2:0] S_DOUT   = 3'd5;
   localparam logic [2:0] S_ACK    = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            ctl.check = 1'b1;
            state_in  = S_LOOKUP;
         end
         S_LOOKUP: begin
            ctl.lookup = 1'b1;
            state_in   = sts.voting ? S_VOTE : S_ACK;
         end
         S_VOTE: begin
            ctl.vote = 1'b1;
            state_in = sts.apply ? S_DRAIN : S_ACK;
         end
         S_DRAIN: begin
            state_in = sts.head_ready ? S_DOUT : S_ACK;
         end
         S_DOUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               ctl.pop  = 1'b1;
               state_in = S_DRAIN;
            end
         end
         S_ACK: begin
            rsp_valid   = 1'b1;
            ctl.out_ack = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/qgrb_dpath.sv =====
// Datapath for the quorum-gated reorder buffer.
// Config registers, window ring (vote and tag memories, applied bits), result mux; uses qgrb_pkg.
module qgrb_dpath #(
   parameter int WINDOW  = 16,
   parameter int SERVERS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [qgrb_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [qgrb_pkg::CSR_W-1:0]        csr_wdata,
   input  qgrb_pkg::req_type                 req_data,
   output qgrb_pkg::rsp_type                 rsp_data,
   input  qgrb_pkg::qgrb_ctl_type            ctl,
   output qgrb_pkg::qgrb_sts_type            sts
);
   import qgrb_pkg::*;

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(SERVERS + 1);
   localparam int CMP_W  = (CNT_W > QUORUM_W) ? CNT_W : QUORUM_W;

   logic [QUORUM_W-1:0] quorum_ff;
   logic [MASK_W-1:0]   mask_ff;

   req_type             req_ff;
   logic                valid_ff;
   logic                inwin_ff;
   logic                behind_ff;
   logic [SLOT_W-1:0]   diff_ff;
   logic [SLOT_W-1:0]   slot_ff;
   logic [STAT_W-1:0]   status_ff;
   logic [STAT_W-1:0]   status_in;
   logic [SEQ_W-1:0]    next_ff;
   logic [SEQ_W-1:0]    next_in;
   logic [SLOT_W-1:0]   head_ff;
   logic [SLOT_W-1:0]   head_in;
   logic [WINDOW-1:0]   applied_ff;
   logic [WINDOW-1:0]   vote_vld_ff;

   logic [SERVERS-1:0]  vote_mem [WINDOW];
   logic [TAG_W-1:0]    tag_mem  [WINDOW];
   logic [SERVERS-1:0]  vote_rd_ff;
   logic                vote_rdv_ff;
   logic [TAG_W-1:0]    tag_rd_ff;

   logic                is_vote;
   logic                sid_ok;
   logic [SEQ_W-1:0]    seq_off;
   logic [SLOT_W:0]     slot_sum;
   logic [SLOT_W-1:0]   slot;
   logic [SERVERS-1:0]  vote_cur;
   logic [SERVERS-1:0]  vote_new;
   logic [CNT_W-1:0]    vote_cnt;
   logic                apply;

   assign is_vote = (req_ff.cmd == CMD_APPEND) || (req_ff.cmd == CMD_SKIP);
   assign sid_ok  = (32'(req_ff.server_id) < SERVERS) && mask_ff[req_ff.server_id];
   assign seq_off = req_ff.seq - next_ff;

   always_comb begin
      slot_sum = {1'b0, head_ff} + {1'b0, diff_ff};
      if (slot_sum >= (SLOT_W+1)'(WINDOW)) begin
         slot_sum = slot_sum - (SLOT_W+1)'(WINDOW);
      end
      slot = slot_sum[SLOT_W-1:0];
   end

   always_comb begin
      vote_cur = vote_rdv_ff ? vote_rd_ff : '0;
      vote_new = vote_cur | (SERVERS'(1) << req_ff.server_id);
      vote_cnt = '0;
      for (int i = 0; i < SERVERS; i++) begin
         vote_cnt = vote_cnt + CNT_W'(vote_new[i]);
      end
      apply = CMP_W'(vote_cnt) >= CMP_W'(quorum_ff);
   end

   always_comb begin
      status_in = status_ff;
      if (ctl.lookup) begin
         if (!is_vote) begin
            status_in = ST_COUNTED;
         end else if (!valid_ff) begin
            status_in = ST_INVALID;
         end else if (!inwin_ff) begin
            status_in = behind_ff ? ST_ALREADY : ST_OUTSIDE;
         end else if (applied_ff[slot]) begin
            status_in = ST_ALREADY;
         end else begin
            status_in = ST_COUNTED;
         end
      end else if (ctl.vote && apply) begin
         status_in = ST_APPLIED;
      end
   end

   assign next_in = next_ff + SEQ_W'(1);
   assign head_in = (head_ff == SLOT_W'(WINDOW - 1)) ? '0 : head_ff + SLOT_W'(1);

   assign sts.voting     = is_vote && valid_ff && inwin_ff && !applied_ff[slot];
   assign sts.apply      = apply;
   assign sts.head_ready = applied_ff[head_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         quorum_ff <= QUORUM_RST;
         mask_ff   <= MASK_RST;
      end else if (csr_we) begin
         if (csr_idx == CSR_QUORUM) begin
            quorum_ff <= csr_wdata[QUORUM_W-1:0];
         end else begin
            mask_ff <= csr_wdata[MASK_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         req_ff <= req_data;
      end
      if (ctl.check) begin
         valid_ff  <= sid_ok;
         inwin_ff  <= seq_off < SEQ_W'(WINDOW);
         behind_ff <= req_ff.seq < next_ff;
         diff_ff   <= seq_off[SLOT_W-1:0];
      end
      if (ctl.lookup) begin
         slot_ff <= slot;
      end
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff     <= NEXT_RST;
         head_ff     <= SLOT_W'(1);
         applied_ff  <= '0;
         vote_vld_ff <= '0;
      end else begin
         if (ctl.vote) begin
            vote_vld_ff[slot_ff] <= 1'b1;
            if (apply) begin
               applied_ff[slot_ff] <= 1'b1;
            end
         end
         if (ctl.pop) begin
            applied_ff[head_ff] <= 1'b0;
            next_ff             <= next_in;
            head_ff             <= head_in;
         end
      end
   end

   // vote memory: read at lookup slot, written back in the vote cycle
   always_ff @(posedge clock) begin
      vote_rd_ff  <= vote_mem[slot];
      vote_rdv_ff <= vote_vld_ff[slot];
      if (ctl.vote) begin
         vote_mem[slot_ff] <= apply ? '0 : vote_new;
      end
   end

   // tag memory: written on apply, read at head every cycle
   always_ff @(posedge clock) begin
      tag_rd_ff <= tag_mem[head_ff];
      if (ctl.vote && apply) begin
         tag_mem[slot_ff] <= req_ff.payload_tag;
      end
   end

   always_comb begin
      if (ctl.out_ack) begin
         rsp_data.kind    = KIND_ACK;
         rsp_data.out_seq = req_ff.seq;
         rsp_data.out_tag = '0;
         rsp_data.status  = status_ff;
         rsp_data.last    = 1'b1;
      end else begin
         rsp_data.kind    = KIND_ENTRY;
         rsp_data.out_seq = next_ff;
         rsp_data.out_tag = tag_rd_ff;
         rsp_data.status  = ST_APPLIED;
         rsp_data.last    = 1'b0;
      end
   end

endmodule

// ===== design/quorum_gated_reorder_buffer_unit.sv =====
// Top level of the quorum-gated reorder buffer.
// Joins qgrb_ctrl and qgrb_dpath; uses qgrb_pkg.
//
//  port group   dir   handshake             beat
//  req_*        in    req_valid/req_ready   one message (qgrb_pkg::req_type)
//  rsp_*        out   rsp_valid/rsp_ready   delivered entry or ack (rsp_type)
//  csr_*        in    csr_we                one register write
//
// One message at a time: accept, window check, slot lookup, vote, ack.
// An ack-only message passes accept, check, lookup and the ack beat; a counted vote adds a vote step.
// An apply adds a head check; each delivered entry adds a beat, then another head check.
// rsp_ready low holds the current beat; req_ready is low until the ack goes.
// Reset clears vote and applied state at once; no clearing pass.
module quorum_gated_reorder_buffer_unit #(
   parameter int WINDOW  = 16,
   parameter int SERVERS = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  qgrb_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output qgrb_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [qgrb_pkg::CSR_IDX_W-1:0]  csr_idx,
   input  logic [qgrb_pkg::CSR_W-1:0]      csr_wdata
);
   import qgrb_pkg::*;

   qgrb_ctl_type ctl;
   qgrb_sts_type sts;

   qgrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   qgrb_dpath #(
      .WINDOW  (WINDOW),
      .SERVERS (SERVERS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .ctl       (ctl),
      .sts       (sts)
   );

endmodule
